// File: sv/stable_level_gauge_defines.svh
// Assertion macros used by the checker file.
`ifndef STABLE_LEVEL_GAUGE_DEFINES_SVH
`define STABLE_LEVEL_GAUGE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SLG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slg check failed");

// Consequence must hold in the cycle after the antecedent.
`define SLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slg check failed");

`endif

// File: sv/slg_pkg.sv
`default_nettype none
package slg_pkg;

  localparam int SUM_W = 27;
  localparam int CNT_W = 11;
  localparam int AVG_W = 24;
  localparam int MM_W = 14;
  localparam int FRAC_W = 17;
  localparam int DIV_NW = 36;
  localparam int DIV_DW = 16;
  localparam int MAX_WINDOW = 1024;
  localparam int TABLE_POINTS = 8;
  localparam int SEG_W = $clog2(TABLE_POINTS);

  localparam logic signed [15:0] FAILED_READ = 16'sh8000;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  // Configuration register indexes.
  localparam logic [2:0] REG_STABLE_MODE = 3'd0;
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd1;
  localparam logic [2:0] REG_FULL_SCALE = 3'd2;
  localparam logic [2:0] REG_DELTA = 3'd3;
  localparam logic [2:0] REG_CONFIRM = 3'd4;

  // Calibration table: Q1.16 fraction points and Q6.8 millimetre levels.
  localparam logic [FRAC_W-1:0] CAL_FRAC [TABLE_POINTS] = '{
    17'd0, 17'd31457, 17'd45875, 17'd52429, 17'd58327, 17'd61604, 17'd63570, 17'd65536
  };
  localparam logic [MM_W-1:0] CAL_MM [TABLE_POINTS] = '{
    14'd0, 14'd1280, 14'd2560, 14'd3840, 14'd5120, 14'd6400, 14'd7680, 14'd8960
  };

  // One completed window handed from the front to the back.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0] good;
  } win_t;

  typedef struct packed {
    logic stable_mode;
    logic [14:0] full_scale;
    logic [22:0] delta;
    logic [7:0] confirm;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_AVG, S_STAB, S_FRAC, S_SEG, S_MUL, S_PART, S_OUT
  } back_state_t;

endpackage
`default_nettype wire

// File: sv/slg_front.sv
`default_nettype none
module slg_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] sample,
  input  wire logic [10:0] wlen,
  input  wire logic q_full,
  output logic win_push,
  output slg_pkg::win_t win
);
  import slg_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] good;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] seen_inc;
  logic is_good;
  logic accept;
  logic close;

  // Effective window length: zero means one, long windows saturate.
  always_comb begin
    if (wlen == '0) len = CNT_W'(1);
    else if (wlen > CNT_W'(MAX_WINDOW)) len = CNT_W'(MAX_WINDOW);
    else len = wlen;
  end

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign is_good = (sample != FAILED_READ);
  assign seen_inc = seen + CNT_W'(1);
  assign close = (seen_inc >= len);

  // The finished window goes straight to the queue.
  assign win.sum = is_good ? sum + SUM_W'(sample) : sum;
  assign win.good = is_good ? good + CNT_W'(1) : good;
  assign win_push = accept && close;

  // Window accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      seen <= '0;
      good <= '0;
    end else if (accept) begin
      if (close) begin
        sum <= '0;
        seen <= '0;
        good <= '0;
      end else begin
        sum <= win.sum;
        seen <= seen_inc;
        good <= win.good;
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/slg_queue.sv
`default_nettype none
module slg_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire slg_pkg::win_t din,
  output logic full,
  input  wire logic pop,
  output logic q_valid,
  output slg_pkg::win_t dout
);
  import slg_pkg::*;

  win_t mem [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign dout = mem[rptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: sv/slg_div.sv
`default_nettype none
module slg_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [35:0] num,
  input  wire logic [15:0] den,
  output logic done,
  output logic [35:0] quot
);
  import slg_pkg::*;

  logic busy;
  logic [5:0] cnt;
  logic [DIV_DW:0] rem;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_DW:0] rem_sh;
  logic ge;

  // One restoring step per cycle, most significant bit first.
  assign rem_sh = {rem[DIV_DW-1:0], quot[DIV_NW-1]};
  assign ge = (rem_sh >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'(DIV_NW - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quot <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? rem_sh - {1'b0, dreg} : rem_sh;
      quot <= {quot[DIV_NW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// File: sv/slg_back.sv
`default_nettype none
module slg_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire slg_pkg::cfg_t cfg,
  input  wire logic q_valid,
  input  wire slg_pkg::win_t q_head,
  output logic pop,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [13:0] level_mm_q8,
  output logic signed [23:0] average_q8,
  output logic failed
);
  import slg_pkg::*;

  back_state_t state, state_next;

  logic neg;
  logic fail_r;
  logic signed [AVG_W-1:0] avg;
  logic signed [AVG_W-1:0] last_avg;
  logic prev_valid;
  logic [7:0] stable_cnt;
  logic [FRAC_W-1:0] frac;
  logic [MM_W-1:0] base_mm;
  logic [15:0] diff;
  logic [MM_W-1:0] rise;
  logic [15:0] span;

  logic div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic div_done;
  logic [DIV_NW-1:0] quot;

  logic [SUM_W-1:0] mag;
  logic head_fail;
  logic [AVG_W-1:0] qa;
  logic signed [AVG_W:0] dd;
  logic [AVG_W:0] dabs;
  logic unstable;
  logic [7:0] cnt_new;
  logic report;
  logic [SEG_W-1:0] seg;

  slg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  assign mag = q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : q_head.sum;
  assign head_fail = (q_head.good == '0) || q_head.sum[SUM_W-1];
  assign qa = quot[AVG_W-1:0];

  // Stability test of the current window average.
  assign dd = (AVG_W+1)'(avg) - (AVG_W+1)'(last_avg);
  assign dabs = dd[AVG_W] ? (AVG_W+1)'(-dd) : dd;
  assign unstable = !prev_valid || (dabs > (AVG_W+1)'(cfg.delta));
  assign cnt_new = unstable ? 8'd0 : ((stable_cnt == 8'd255) ? stable_cnt : stable_cnt + 8'd1);
  assign report = (cnt_new >= cfg.confirm);

  // Calibration segment that holds the fraction.
  always_comb begin
    seg = SEG_W'(TABLE_POINTS - 1);
    for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
      if (frac <= CAL_FRAC[i]) seg = SEG_W'(i);
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next state, queue pop, divider control and output valid.
  always_comb begin
    state_next = state;
    pop = 1'b0;
    div_start = 1'b0;
    div_num = {1'b0, mag, 8'd0};
    div_den = {5'd0, q_head.good};
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_head.good != '0) begin
            div_start = 1'b1;
            state_next = S_AVG;
          end else begin
            state_next = S_STAB;
          end
        end
      end
      S_AVG: begin
        if (div_done) state_next = S_STAB;
      end
      S_STAB: begin
        div_num = {4'd0, avg, 8'd0};
        div_den = (cfg.full_scale == '0) ? 16'd1 : {1'b0, cfg.full_scale};
        if (cfg.stable_mode && (fail_r || !report)) begin
          state_next = S_IDLE;
        end else if (fail_r || avg <= 0) begin
          state_next = S_OUT;
        end else begin
          div_start = 1'b1;
          state_next = S_FRAC;
        end
      end
      S_FRAC: begin
        if (div_done) state_next = S_SEG;
      end
      S_SEG: begin
        if (frac == '0 || frac >= FRAC_ONE) state_next = S_OUT;
        else state_next = S_MUL;
      end
      S_MUL: begin
        div_num = DIV_NW'(diff * rise);
        div_den = span;
        div_start = 1'b1;
        state_next = S_PART;
      end
      S_PART: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Stability state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_avg <= '0;
      prev_valid <= 1'b0;
      stable_cnt <= '0;
    end else if (state == S_STAB && cfg.stable_mode && !fail_r) begin
      if (report) begin
        last_avg <= '0;
        prev_valid <= 1'b0;
        stable_cnt <= '0;
      end else begin
        last_avg <= avg;
        prev_valid <= 1'b1;
        stable_cnt <= cnt_new;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        neg <= q_head.sum[SUM_W-1];
        fail_r <= head_fail;
        avg <= '0;
      end
      S_AVG: begin
        if (div_done) avg <= neg ? AVG_W'(-qa) : qa;
      end
      S_STAB: begin
        level_mm_q8 <= '0;
        average_q8 <= avg;
        failed <= fail_r;
      end
      S_FRAC: begin
        if (div_done) frac <= (quot > DIV_NW'(FRAC_ONE)) ? FRAC_ONE : quot[FRAC_W-1:0];
      end
      S_SEG: begin
        if (frac >= FRAC_ONE) level_mm_q8 <= CAL_MM[TABLE_POINTS-1];
        base_mm <= CAL_MM[seg - SEG_W'(1)];
        diff <= 16'(frac - CAL_FRAC[seg - SEG_W'(1)]);
        rise <= CAL_MM[seg] - CAL_MM[seg - SEG_W'(1)];
        span <= 16'(CAL_FRAC[seg] - CAL_FRAC[seg - SEG_W'(1)]);
      end
      S_PART: begin
        if (div_done) level_mm_q8 <= base_mm + quot[MM_W-1:0];
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// File: sv/stable_level_gauge.sv
// A result is offered with no division if the window had no good sample, after the average
// division if the average alone decides it, after the fraction division if the fraction
// is zero or clamps to one, and after the interpolation division otherwise. In stable mode
// only confirmed-stable windows are offered. Windows go one at a time through the shared
// 36-step divider; samples take one cycle each while the two-entry window queue has room.
// Synchronous reset (rst) clears the window and stability history and sets default config.
`default_nettype none
module stable_level_gauge (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] sample,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [13:0] level_mm_q8,
  output logic signed [23:0] average_q8,
  output logic failed,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [22:0] cfg_data
);
  import slg_pkg::*;

  cfg_t cfg;
  logic [10:0] wlen;
  win_t win;
  win_t q_head;
  logic win_push;
  logic q_full;
  logic q_valid;
  logic pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_mode <= 1'b0;
      wlen <= 11'd16;
      cfg.full_scale <= 15'd2047;
      cfg.delta <= 23'd2560;
      cfg.confirm <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STABLE_MODE: cfg.stable_mode <= cfg_data[0];
        REG_WINDOW_LENGTH: wlen <= cfg_data[10:0];
        REG_FULL_SCALE: cfg.full_scale <= cfg_data[14:0];
        REG_DELTA: cfg.delta <= cfg_data;
        REG_CONFIRM: cfg.confirm <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  slg_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .wlen(wlen), .q_full(q_full), .win_push(win_push), .win(win)
  );

  slg_queue u_queue (
    .clk(clk), .rst(rst), .push(win_push), .din(win), .full(q_full),
    .pop(pop), .q_valid(q_valid), .dout(q_head)
  );

  slg_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_head(q_head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .level_mm_q8(level_mm_q8),
    .average_q8(average_q8), .failed(failed)
  );
endmodule
`default_nettype wire

// File: sv/slg_checker.sv
`default_nettype none
`include "stable_level_gauge_defines.svh"
module slg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [13:0] level_mm_q8,
  input wire logic signed [23:0] average_q8,
  input wire logic failed
);
  // A stalled result stays offered.
  `SLG_ASSERT_NEXT(hold_valid, out_valid && out_stall, out_valid)
  // A failed window reports no level.
  `SLG_ASSERT_NOW(fail_zero, out_valid && failed, level_mm_q8 == 14'd0)
  // The level never exceeds the top of the calibration table.
  `SLG_ASSERT_NOW(level_max, out_valid, level_mm_q8 <= 14'd8960)
  // A negative average is always flagged as failed.
  `SLG_ASSERT_NOW(neg_fails, out_valid && average_q8[23], failed)
endmodule

bind stable_level_gauge slg_checker u_slg_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .level_mm_q8(level_mm_q8), .average_q8(average_q8), .failed(failed)
);
`default_nettype wire
